[rtl/core/swmf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// swmf_pkg: shared types for the sliding-window median filter
// Sample, widened sum and per-cell state types used by the filter.
// ----------------------------------------------------------------------------
package swmf_pkg;

    localparam int SAMPLE_W = 16;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [SAMPLE_W:0]   t_sum;

    // state a cell shows to its neighbours
    typedef struct packed {
        logic    valid;
        t_sample value;
    } t_cell;

endpackage
`default_nettype wire

[rtl/core/swmf_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// swmf_cell: one slot of the sorted window
// Holds one sample of the ascending chain; on each insert takes its new
// value from itself or a neighbour, or takes the incoming sample.
// ----------------------------------------------------------------------------
module swmf_cell
    import swmf_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_en,
    input  wire logic    i_remove,
    input  wire t_sample i_sample,
    input  wire t_sample i_oldest,
    input  wire logic    i_fill,
    input  wire t_cell   i_left,
    input  wire t_cell   i_right,
    output t_cell        o_state
);

    logic    r_valid;
    t_sample r_value;
    t_sample n_value;
    t_cell   w_self;
    t_cell   w_own;
    t_cell   w_prev;
    logic    w_shift_self;
    logic    w_shift_left;

    always_comb begin
        w_self       = '{valid: r_valid, value: r_value};
        // the dropped entry sits at or below this slot: close the gap
        w_shift_self = i_remove && r_valid && (r_value >= i_oldest);
        w_shift_left = i_remove && i_left.valid && (i_left.value >= i_oldest);
        w_own        = w_shift_self ? i_right : w_self;
        w_prev       = w_shift_left ? w_self  : i_left;
        if (w_own.valid && (w_own.value <= i_sample)) begin
            n_value = w_own.value;
        end else if (w_prev.valid && (w_prev.value > i_sample)) begin
            n_value = w_prev.value;
        end else begin
            n_value = i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_value <= n_value;
        end
    end

    assign o_state = w_self;

endmodule
`default_nettype wire

[rtl/core/swmf_history.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// swmf_history: arrival-order delay line
// Remembers the last DEPTH samples so the oldest can be dropped from the chain.
// ----------------------------------------------------------------------------
module swmf_history
    import swmf_pkg::*;
#(
    parameter int DEPTH = 8
) (
    input  wire logic    i_clk,
    input  wire logic    i_en,
    input  wire t_sample i_sample,
    output t_sample      o_oldest
);

    t_sample r_taps [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_taps[0] <= i_sample;
            for (int k = 1; k < DEPTH; k++) begin
                r_taps[k] <= r_taps[k-1];
            end
        end
    end

    assign o_oldest = r_taps[DEPTH-1];

endmodule
`default_nettype wire

[rtl/core/sliding_window_median_filter_unit.sv]
// Pipeline: cell chain, then middle-cell select, then averaged median register.
// Throughput: one word per cycle; the whole pipeline holds while the output
// word is stalled, and the input is stalled only then.
// Reset: synchronous, active low; empties the window and drops words in flight.
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_window_median_filter_unit: running median over the last samples
// A chain of cells keeps the window sorted. Each accepted word drops the
// oldest sample (once the window is full) and inserts the new one in the
// same update; the middle cells are then picked and averaged.
// ----------------------------------------------------------------------------
module sliding_window_median_filter_unit
    import swmf_pkg::*;
#(
    parameter int WINDOW_LENGTH = 8
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_stall,
    input  wire t_sample i_sample,
    output logic         o_valid,
    input  wire logic    i_stall,
    output t_sample      o_median,
    output logic         o_window_full
);

    localparam int CW = $clog2(WINDOW_LENGTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(WINDOW_LENGTH);

    // pipeline control
    logic          w_adv;
    logic          w_accept;
    logic          r_pend;
    logic          r_sel_valid;
    logic          r_out_valid;

    // window state
    logic [CW-1:0] r_count;
    logic          w_full;
    t_sample       w_oldest;
    t_cell         w_cells [WINDOW_LENGTH];

    // selection and output
    logic [CW-1:0] w_lo_idx;
    logic [CW-1:0] w_hi_idx;
    t_sample       n_sel_lo;
    t_sample       n_sel_hi;
    t_sample       r_sel_lo;
    t_sample       r_sel_hi;
    logic          r_sel_full;
    t_sum          w_sum;
    t_sum          w_sum_adj;
    t_sample       r_median;
    logic          r_out_full;

    // Advance everything together unless the output word is held.
    assign w_adv    = !r_out_valid || !i_stall;
    assign w_accept = i_valid && w_adv;
    assign o_stall  = !w_adv;
    assign w_full   = (r_count == FULL_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= 1'b0;
            r_sel_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else if (w_adv) begin
            r_pend      <= w_accept;
            r_sel_valid <= r_pend;
            r_out_valid <= r_sel_valid;
            if (w_accept && !w_full) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    // Arrival order: the tap at the far end is the sample to drop when full.
    swmf_history #(
        .DEPTH (WINDOW_LENGTH)
    ) u_history (
        .i_clk    (i_clk),
        .i_en     (w_accept),
        .i_sample (i_sample),
        .o_oldest (w_oldest)
    );

    // Sorted chain, ascending from cell 0. Valid bits fill from cell 0 upward.
    for (genvar g = 0; g < WINDOW_LENGTH; g++) begin : g_cell
        t_cell w_left;
        t_cell w_right;
        logic  w_fill;

        if (g == 0) begin : g_head
            assign w_left = '0;
            assign w_fill = 1'b1;
        end else begin : g_body
            assign w_left = w_cells[g-1];
            assign w_fill = w_cells[g-1].valid;
        end

        if (g == WINDOW_LENGTH - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_inner
            assign w_right = w_cells[g+1];
        end

        swmf_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (w_accept),
            .i_remove (w_full),
            .i_sample (i_sample),
            .i_oldest (w_oldest),
            .i_fill   (w_fill),
            .i_left   (w_left),
            .i_right  (w_right),
            .o_state  (w_cells[g])
        );
    end

    // Pick the two middle cells; with an odd count both are the same cell.
    assign w_lo_idx = (r_count - 1'b1) >> 1;
    assign w_hi_idx = r_count >> 1;

    always_comb begin
        n_sel_lo = '0;
        n_sel_hi = '0;
        for (int k = 0; k < WINDOW_LENGTH; k++) begin
            if (w_lo_idx == CW'(k)) begin
                n_sel_lo = n_sel_lo | w_cells[k].value;
            end
            if (w_hi_idx == CW'(k)) begin
                n_sel_hi = n_sel_hi | w_cells[k].value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sel_lo   <= n_sel_lo;
            r_sel_hi   <= n_sel_hi;
            r_sel_full <= w_full;
        end
    end

    // Average in 17 bits; add one to negative sums so the halving truncates
    // toward zero.
    assign w_sum     = t_sum'(r_sel_lo) + t_sum'(r_sel_hi);
    assign w_sum_adj = w_sum + t_sum'({{SAMPLE_W{1'b0}}, w_sum[SAMPLE_W]});

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_median   <= t_sample'(w_sum_adj[SAMPLE_W:1]);
            r_out_full <= r_sel_full;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_median      = r_median;
    assign o_window_full = r_out_full;

endmodule
`default_nettype wire
